FILE: src/urd_pkg.sv
// shared types and constants for the uniform random draw unit
package urd_pkg;

  localparam int unsigned SeedW = 31;
  localparam int unsigned DataW = 32;
  localparam int unsigned OpaW  = 33;
  localparam int unsigned ProdW = 64;

  localparam logic [SeedW-1:0] LcgMult   = 31'd16807;
  localparam logic [SeedW-1:0] LcgMod    = 31'h7fff_ffff;
  localparam logic [SeedW-1:0] SeedReset = 31'd123456789;

  localparam logic CmdReal = 1'b0;
  localparam logic CmdInt  = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic signed [DataW-1:0] range_low;
    logic signed [DataW-1:0] range_high;
  } urd_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic [SeedW-1:0]        raw_seed;
  } urd_rsp_t;

  function automatic logic [SeedW-1:0] legal_seed(input logic [DataW-1:0] v);
    logic [SeedW-1:0] s;
    s = v[SeedW-1:0];
    if (s == '0 || s == LcgMod) begin
      s = SeedW'(1);
    end
    return s;
  endfunction

endpackage

FILE: src/urd_mul.sv
// shared unsigned multiplier with registered product
module urd_mul (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [urd_pkg::OpaW-1:0]  a_i,
  input  logic [urd_pkg::SeedW-1:0] b_i,
  output logic [urd_pkg::ProdW-1:0] p_o
);
  import urd_pkg::*;

  logic [ProdW-1:0] p_q;
  logic [ProdW-1:0] p_d;

  assign p_d = ProdW'(a_i) * ProdW'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

FILE: src/uniform_random_draw_unit.sv
// uniform random draw unit: park-miller generator with range scaling
// steps per item: seed multiply, fold, range multiply, then StFin1 and StFin2 finish the result
// a new item is taken only in idle, after the last result is loaded; the single shared
//   multiplier is used twice per item (seed step, then range scaling)
// reset: generator and seed register return to 123456789, no item pending
module uniform_random_draw_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  urd_pkg::urd_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output urd_pkg::urd_rsp_t rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import urd_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul1 = 3'd1;
  localparam logic [2:0] StFold = 3'd2;
  localparam logic [2:0] StMul2 = 3'd3;
  localparam logic [2:0] StFin1 = 3'd4;
  localparam logic [2:0] StFin2 = 3'd5;

  logic [2:0]              st_q, st_d;
  logic [SeedW-1:0]        seed_start_q;
  logic [SeedW-1:0]        lcg_q, lcg_d;
  urd_req_t                req_q;
  logic [OpaW-1:0]         opa_q, opa_d;
  logic signed [DataW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic                    neg_q, neg_d;
  logic signed [65:0]      y_q, y_d;
  logic signed [DataW-1:0] res_q, res_d;
  logic                    rsp_valid_q;
  urd_rsp_t                rsp_q;

  logic                    req_fire, cfg_we, mul_en, rsp_load;
  logic [OpaW-1:0]         mul_a;
  logic [ProdW-1:0]        prod;
  logic signed [OpaW-1:0]  lo33, hi33, diff;
  logic [DataW-1:0]        fold_sum;
  logic [OpaW-1:0]         t;
  logic signed [34:0]      q, lo35, hi35, qc;
  logic                    y_neg, q_dec;

  assign req_ready_o = (st_q == StIdle);
  assign req_fire    = req_valid_i & req_ready_o;
  assign cfg_we      = psel & penable & pwrite & ~paddr[2];
  assign pready      = 1'b1;
  assign prdata      = {1'b0, seed_start_q};

  // shared multiplier: seed step, then range scaling
  assign mul_en = (st_q == StMul1) | (st_q == StMul2);
  assign mul_a  = (st_q == StMul1) ? OpaW'(LcgMult) : opa_q;

  urd_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (lcg_q),
    .p_o   (prod)
  );

  // operand setup beside the first multiply
  assign lo33 = OpaW'(req_q.range_low);
  assign hi33 = OpaW'(req_q.range_high);
  assign diff = hi33 - lo33;

  always_comb begin
    neg_d = neg_q;
    lo_d  = lo_q;
    hi_d  = hi_q;
    opa_d = opa_q;
    if (st_q == StMul1) begin
      if (req_q.cmd == CmdReal) begin
        neg_d = diff[OpaW-1];
        lo_d  = req_q.range_low;
        hi_d  = req_q.range_high;
        opa_d = diff[OpaW-1] ? OpaW'(-diff) : OpaW'(diff);
      end else begin
        neg_d = 1'b0;
        if (req_q.range_high < req_q.range_low) begin
          lo_d  = req_q.range_high;
          hi_d  = req_q.range_low;
          opa_d = OpaW'(lo33 - hi33 + OpaW'(1));
        end else begin
          lo_d  = req_q.range_low;
          hi_d  = req_q.range_high;
          opa_d = OpaW'(diff + OpaW'(1));
        end
      end
    end
  end

  // mod 2^31-1 fold of the seed product
  assign fold_sum = DataW'(prod[45:31]) + DataW'(prod[30:0]);

  always_comb begin
    lcg_d = lcg_q;
    if (cfg_we) begin
      lcg_d = legal_seed(pwdata);
    end else if (st_q == StFold) begin
      if (fold_sum >= DataW'(LcgMod)) begin
        lcg_d = SeedW'(fold_sum - DataW'(LcgMod));
      end else begin
        lcg_d = fold_sum[SeedW-1:0];
      end
    end
  end

  // scaling: real offset or integer value in units of 2^-31
  assign t = prod[63:31];

  always_comb begin
    res_d = res_q;
    y_d   = y_q;
    if (st_q == StFin1) begin
      if (neg_q) begin
        res_d = DataW'(OpaW'(lo_q) - t);
      end else begin
        res_d = DataW'(OpaW'(lo_q) + t);
      end
      y_d = $signed({2'b00, prod}) + ($signed(66'(lo_q)) <<< 31);
    end
  end

  // floor to an integer (one less when y is below 2^30 with a zero fraction), then clamp to [lo, hi]
  assign y_neg = (y_q < $signed(66'(1) <<< 30));
  assign q_dec = y_neg & (y_q[30:0] == '0);
  assign q     = $signed(y_q[65:31]) - $signed(35'(q_dec));
  assign lo35  = 35'(lo_q);
  assign hi35  = 35'(hi_q);

  always_comb begin
    qc = q;
    if (q < lo35) begin
      qc = lo35;
    end else if (q > hi35) begin
      qc = hi35;
    end
  end

  assign rsp_load = (st_q == StFin2) & (~rsp_valid_q | rsp_ready_i);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (req_fire) begin
        st_d = StMul1;
      end
      StMul1: st_d = StFold;
      StFold: st_d = StMul2;
      StMul2: st_d = StFin1;
      StFin1: st_d = StFin2;
      StFin2: if (rsp_load) begin
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= StIdle;
      seed_start_q <= SeedReset;
      lcg_q        <= SeedReset;
      rsp_valid_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      lcg_q <= lcg_d;
      if (cfg_we) begin
        seed_start_q <= legal_seed(pwdata);
      end
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q <= req_i;
    end
    opa_q <= opa_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    neg_q <= neg_d;
    res_q <= res_d;
    y_q   <= y_d;
    if (rsp_load) begin
      rsp_q.value    <= (req_q.cmd == CmdInt) ? DataW'(qc) : res_q;
      rsp_q.raw_seed <= lcg_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

FILE: src/urd_chk.sv
// port-level checker for the uniform random draw unit, with its bind
module urd_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_o,
  input logic              rsp_valid_o,
  input logic              rsp_ready_i,
  input urd_pkg::urd_rsp_t rsp_o
);
  import urd_pkg::*;

  a_seed_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.raw_seed != '0 && rsp_o.raw_seed != LcgMod))
    else $error("raw seed out of generator range");

  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> !req_ready_o)
    else $error("ready high right after an item");

  a_rsp_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> !$past(req_ready_o))
    else $error("result appeared without work in progress");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |=> (rsp_valid_o && $stable(rsp_o)))
    else $error("stalled result changed");

endmodule

bind uniform_random_draw_unit urd_chk u_urd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_ready_o (req_ready_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);
